>>> hw/rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants of the line stepper: request and pixel words,
// queue commands and the clipping view of the frame.
// ----------------------------------------------------------------------------
package bls_pkg;

	// Coordinate and frame dimension widths
	localparam int COORD_BITS  = 12;
	localparam int DIM_BITS    = 11;
	localparam int COLOR_BITS  = 8;
	localparam int ERR_BITS    = 14;

	// Clipping limits; a larger programmed size saturates to these
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;

	// Default depth of the command queue
	localparam int QUEUE_DEPTH = 4;

	// Request type codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_READY = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic        [COORD_BITS-1:0] delta_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic        [DIM_BITS-1:0]   dim_t;
	typedef logic        [COLOR_BITS-1:0] color_t;

	// Input word
	typedef struct packed {
		logic   req_type;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
		color_t red_in;
		color_t green_in;
		color_t blue_in;
	} req_t;

	// Output word
	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		color_t red_out;
		color_t green_out;
		color_t blue_out;
		logic   in_frame;
		logic   last_point;
	} pix_t;

	// Command classes handed from front to back
	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_DROP,
		CMD_STEP
	} cmd_kind_t;

	// Queue entry: a classified request with its line setup worked out
	typedef struct packed {
		cmd_kind_t kind;
		coord_t    cur_x;
		coord_t    cur_y;
		coord_t    target_x;
		coord_t    target_y;
		delta_t    delta_x;
		delta_t    delta_y;
		logic      step_x_neg;
		logic      step_y_neg;
		err_t      error_term;
		color_t    red;
		color_t    green;
		color_t    blue;
	} cmd_t;

	// Frame view used for clipping
	typedef struct packed {
		dim_t clip_w;
		dim_t clip_h;
		logic ready;
	} frame_t;

endpackage

>>> hw/rtl/bresenham_line_stepper_top.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper_top
// Line rasterizer with clipping: front classifier, command queue and
// stepping back end.
// ----------------------------------------------------------------------------
// For each request word a start loads a line (or drops it when the
// frame is not ready) and a step emits one pixel word while a line is
// open, so with pix_ready held high the block sustains one word per
// clock. A step's pixel passes through the command queue and then the
// output register. The rate is set by the back end's single error
// update, two compares and two adds per pixel. The QUEUE_DEPTH-entry
// command queue lets requests keep flowing while the pixel side
// stalls. Configuration writes are taken on every cycle.
module bresenham_line_stepper_top #(
	parameter int QUEUE_DEPTH = bls_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bls_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [bls_pkg::DIM_BITS-1:0]     cfg_data,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  bls_pkg::req_t                    req,
	output logic                             pix_valid,
	input  logic                             pix_ready,
	output bls_pkg::pix_t                    pix
);
	import bls_pkg::*;

	cmd_t   front_cmd;
	cmd_t   back_cmd;
	frame_t frame;
	logic   back_valid;
	logic   back_ready;

	// Classify requests and hold configuration
	bls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (front_cmd),
		.frame     (frame)
	);

	// Decouple front and back
	bls_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (req_valid),
		.push_ready (req_ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	// Step lines and emit pixels
	bls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.frame     (frame),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

endmodule

>>> hw/rtl/bls_front.sv
// ----------------------------------------------------------------------------
// bls_front
// Holds the configuration registers, classifies each request word and
// works out the line setup (deltas, step signs, initial error) for starts.
// ----------------------------------------------------------------------------
module bls_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bls_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bls_pkg::DIM_BITS-1:0]      cfg_data,
	input  bls_pkg::req_t                     req,
	output bls_pkg::cmd_t                     cmd,
	output bls_pkg::frame_t                   frame
);
	import bls_pkg::*;

	dim_t                  clip_w_q;
	dim_t                  clip_h_q;
	logic                  target_ready_q;
	logic signed [COORD_BITS:0] diff_x;
	logic signed [COORD_BITS:0] diff_y;
	logic signed [COORD_BITS:0] abs_x;
	logic signed [COORD_BITS:0] abs_y;

	assign cfg_ready = 1'b1;

	// Write configuration, saturating the frame size to the clip limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_w_q       <= '0;
			clip_h_q       <= '0;
			target_ready_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					clip_w_q <= (cfg_data > DIM_BITS'(MAX_WIDTH)) ?
						DIM_BITS'(MAX_WIDTH) : cfg_data;
				end
				CFG_IMAGE_HEIGHT: begin
					clip_h_q <= (cfg_data > DIM_BITS'(MAX_HEIGHT)) ?
						DIM_BITS'(MAX_HEIGHT) : cfg_data;
				end
				CFG_TARGET_READY: begin
					target_ready_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign frame = '{clip_w: clip_w_q, clip_h: clip_h_q, ready: target_ready_q};

	// Signed differences and their magnitudes
	assign diff_x = {req.end_x[COORD_BITS-1], req.end_x} -
		{req.start_x[COORD_BITS-1], req.start_x};
	assign diff_y = {req.end_y[COORD_BITS-1], req.end_y} -
		{req.start_y[COORD_BITS-1], req.start_y};
	assign abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
	assign abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;

	// Classify the word and build its queue entry
	always_comb begin
		cmd            = '0;
		cmd.cur_x      = req.start_x;
		cmd.cur_y      = req.start_y;
		cmd.target_x   = req.end_x;
		cmd.target_y   = req.end_y;
		cmd.delta_x    = abs_x[COORD_BITS-1:0];
		cmd.delta_y    = abs_y[COORD_BITS-1:0];
		cmd.step_x_neg = diff_x[COORD_BITS] || (diff_x == '0);
		cmd.step_y_neg = diff_y[COORD_BITS] || (diff_y == '0);
		cmd.error_term = ERR_BITS'({2'b00, abs_x[COORD_BITS-1:0]}) -
			ERR_BITS'({2'b00, abs_y[COORD_BITS-1:0]});
		cmd.red        = req.red_in;
		cmd.green      = req.green_in;
		cmd.blue       = req.blue_in;
		if (req.req_type == REQ_STEP) begin
			cmd.kind = CMD_STEP;
		end else if (target_ready_q) begin
			cmd.kind = CMD_LOAD;
		end else begin
			cmd.kind = CMD_DROP;
		end
	end

endmodule

>>> hw/rtl/bls_queue.sv
// ----------------------------------------------------------------------------
// bls_queue
// Small register queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module bls_queue #(
	parameter int DEPTH = bls_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  bls_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output bls_pkg::cmd_t pop_data
);
	import bls_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/bls_back.sv
// ----------------------------------------------------------------------------
// bls_back
// Line state and stepping: loads or drops lines; a step command on an open
// line emits one point into the output register and steps by the error rule.
// ----------------------------------------------------------------------------
module bls_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  bls_pkg::cmd_t   cmd,
	input  bls_pkg::frame_t frame,
	output logic            pix_valid,
	input  logic            pix_ready,
	output bls_pkg::pix_t   pix
);
	import bls_pkg::*;

	localparam int E2_BITS = ERR_BITS + 1;

	logic   busy_q;
	coord_t cur_x_q;
	coord_t cur_y_q;
	coord_t target_x_q;
	coord_t target_y_q;
	delta_t delta_x_q;
	delta_t delta_y_q;
	logic   step_x_neg_q;
	logic   step_y_neg_q;
	err_t   error_q;
	color_t red_q;
	color_t green_q;
	color_t blue_q;
	logic   pix_valid_q;
	pix_t   pix_q;

	logic                      pop;
	logic                      last;
	logic                      in_clip;
	logic signed [E2_BITS-1:0] e2;
	logic signed [E2_BITS-1:0] neg_dy;
	logic signed [E2_BITS-1:0] pos_dx;
	logic                      move_x;
	logic                      move_y;
	err_t                      err_x;
	err_t                      err_next;

	assign cmd_ready = !pix_valid_q || pix_ready;
	assign pop       = cmd_valid && cmd_ready;
	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	// Point classification against the frame and the endpoint
	assign last    = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);
	assign in_clip = frame.ready &&
		!cur_x_q[COORD_BITS-1] && (cur_x_q < $signed({1'b0, frame.clip_w})) &&
		!cur_y_q[COORD_BITS-1] && (cur_y_q < $signed({1'b0, frame.clip_h}));

	// Error rule: decide both moves from twice the error
	assign e2       = {error_q, 1'b0};
	assign neg_dy   = -$signed({{(E2_BITS-COORD_BITS){1'b0}}, delta_y_q});
	assign pos_dx   = $signed({{(E2_BITS-COORD_BITS){1'b0}}, delta_x_q});
	assign move_x   = (e2 > neg_dy);
	assign move_y   = (e2 < pos_dx);
	assign err_x    = move_x ? error_q - ERR_BITS'(delta_y_q) : error_q;
	assign err_next = move_y ? err_x + ERR_BITS'(delta_x_q) : err_x;

	// Hold line flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
			if (pop) begin
				case (cmd.kind)
					CMD_LOAD: begin
						busy_q <= 1'b1;
					end
					CMD_DROP: begin
						busy_q <= 1'b0;
					end
					CMD_STEP: begin
						if (busy_q) begin
							pix_valid_q <= 1'b1;
							if (last) begin
								busy_q <= 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Load line setup, emit the point and advance
	always_ff @(posedge clk) begin
		if (pop && cmd.kind == CMD_LOAD) begin
			cur_x_q      <= cmd.cur_x;
			cur_y_q      <= cmd.cur_y;
			target_x_q   <= cmd.target_x;
			target_y_q   <= cmd.target_y;
			delta_x_q    <= cmd.delta_x;
			delta_y_q    <= cmd.delta_y;
			step_x_neg_q <= cmd.step_x_neg;
			step_y_neg_q <= cmd.step_y_neg;
			error_q      <= cmd.error_term;
			red_q        <= cmd.red;
			green_q      <= cmd.green;
			blue_q       <= cmd.blue;
		end else if (pop && cmd.kind == CMD_STEP && busy_q) begin
			pix_q <= '{pixel_x: cur_x_q, pixel_y: cur_y_q, red_out: red_q,
				green_out: green_q, blue_out: blue_q, in_frame: in_clip,
				last_point: last};
			if (!last) begin
				error_q <= err_next;
				if (move_x) begin
					cur_x_q <= step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
				end
				if (move_y) begin
					cur_y_q <= step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/bls_checker.sv
// ----------------------------------------------------------------------------
// bls_checker
// Port-level checks of the line stepper, bound to the top level.
// ----------------------------------------------------------------------------
module bls_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          pix_valid,
	input logic          pix_ready,
	input bls_pkg::pix_t pix
);
	import bls_pkg::*;

	// Hold a stalled pixel word
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("pixel word changed or dropped while stalled");

	// Clear output after reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !pix_valid)
		else $error("pixel word shown right after reset");

	// Keep in-frame columns within the clip limit
	a_clip_x: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix.in_frame |->
			!pix.pixel_x[COORD_BITS-1] && (pix.pixel_x < COORD_BITS'(MAX_WIDTH)))
		else $error("in-frame pixel column outside clip range");

	// Keep in-frame rows within the clip limit
	a_clip_y: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix.in_frame |->
			!pix.pixel_y[COORD_BITS-1] && (pix.pixel_y < COORD_BITS'(MAX_HEIGHT)))
		else $error("in-frame pixel row outside clip range");

endmodule

bind bresenham_line_stepper_top bls_checker u_bls_checker (.*);

>>> tb/sv/bls_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bls_tb_pkg
// Line scoreboard for the line stepper bench: tracks the frame registers and
// the line in progress, predicts each pixel word and checks the DUT output.
// ----------------------------------------------------------------------------
package bls_tb_pkg;

	import bls_pkg::*;

	class line_scoreboard;
		// Frame registers as last written
		int unsigned frame_w;
		int unsigned frame_h;
		bit          frame_rdy;

		// Line in progress
		bit          line_busy;
		int          cur_x, cur_y, tgt_x, tgt_y;
		int          dx, dy, err;
		bit          neg_x, neg_y;
		color_t      red, green, blue;

		// Pixel words still owed by the DUT
		pix_t        pixel_q[$];

		int unsigned mismatches;
		int unsigned pixels_checked;
		int unsigned starts;
		int unsigned drops;
		int unsigned idle_steps;
		int unsigned items_counted;
		int unsigned cfg_writes;

		function new();
			frame_w        = 0;
			frame_h        = 0;
			frame_rdy      = 1'b0;
			line_busy      = 1'b0;
			cur_x          = 0;
			cur_y          = 0;
			tgt_x          = 0;
			tgt_y          = 0;
			dx             = 0;
			dy             = 0;
			err            = 0;
			neg_x          = 1'b0;
			neg_y          = 1'b0;
			red            = '0;
			green          = '0;
			blue           = '0;
			mismatches     = 0;
			pixels_checked = 0;
			starts         = 0;
			drops          = 0;
			idle_steps     = 0;
			items_counted  = 0;
			cfg_writes     = 0;
		endfunction

		function int unsigned pending();
			return pixel_q.size();
		endfunction

		// Mirror one accepted register write
		function void write_register(logic [CFG_IDX_BITS-1:0] idx, dim_t data);
			cfg_writes++;
			case (idx)
				CFG_IMAGE_WIDTH:  frame_w   = data;
				CFG_IMAGE_HEIGHT: frame_h   = data;
				CFG_TARGET_READY: frame_rdy = data[0];
				default: ;
			endcase
		endfunction

		// Advance the line for one accepted request word
		function void note_request(req_t r);
			int   w, h, e2;
			pix_t p;
			if (r.req_type == REQ_START) begin
				starts++;
				items_counted++;
				// Drop the line when the frame is not ready
				if (!frame_rdy) begin
					drops++;
					line_busy = 1'b0;
					return;
				end
				cur_x = r.start_x;
				cur_y = r.start_y;
				tgt_x = r.end_x;
				tgt_y = r.end_y;
				dx    = (tgt_x > cur_x) ? tgt_x - cur_x : cur_x - tgt_x;
				dy    = (tgt_y > cur_y) ? tgt_y - cur_y : cur_y - tgt_y;
				neg_x = !(cur_x < tgt_x);
				neg_y = !(cur_y < tgt_y);
				err   = dx - dy;
				red   = r.red_in;
				green = r.green_in;
				blue  = r.blue_in;
				line_busy = 1'b1;
				return;
			end
			items_counted++;
			if (!line_busy) begin
				idle_steps++;
				return;
			end
			// Clip against the saturated frame size
			w = (frame_w > MAX_WIDTH)  ? MAX_WIDTH  : frame_w;
			h = (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h;
			p.pixel_x    = cur_x[COORD_BITS-1:0];
			p.pixel_y    = cur_y[COORD_BITS-1:0];
			p.red_out    = red;
			p.green_out  = green;
			p.blue_out   = blue;
			p.in_frame   = frame_rdy && (cur_x >= 0) && (cur_x < w) &&
			               (cur_y >= 0) && (cur_y < h);
			p.last_point = (cur_x == tgt_x) && (cur_y == tgt_y);
			pixel_q.push_back(p);
			// Finish on the second endpoint, else take one error step
			if (p.last_point) begin
				line_busy = 1'b0;
			end else begin
				e2 = 2 * err;
				if (e2 > -dy) begin
					err   -= dy;
					cur_x += neg_x ? -1 : 1;
				end
				if (e2 < dx) begin
					err   += dx;
					cur_y += neg_y ? -1 : 1;
				end
			end
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%t mismatch: %s", $time, msg);
		endfunction

		// Compare one accepted pixel word with the oldest prediction
		function void check_pixel(pix_t got);
			pix_t  want;
			string diff;
			pixels_checked++;
			if (pixel_q.size() == 0) begin
				report($sformatf("pixel word with none pending: x=%0d y=%0d",
					got.pixel_x, got.pixel_y));
				return;
			end
			want = pixel_q.pop_front();
			diff = "";
			if (got.pixel_x !== want.pixel_x)
				diff = {diff, $sformatf(" pixel_x exp %0d got %0d", want.pixel_x, got.pixel_x)};
			if (got.pixel_y !== want.pixel_y)
				diff = {diff, $sformatf(" pixel_y exp %0d got %0d", want.pixel_y, got.pixel_y)};
			if (got.red_out !== want.red_out)
				diff = {diff, $sformatf(" red exp %02h got %02h", want.red_out, got.red_out)};
			if (got.green_out !== want.green_out)
				diff = {diff, $sformatf(" green exp %02h got %02h", want.green_out,
					got.green_out)};
			if (got.blue_out !== want.blue_out)
				diff = {diff, $sformatf(" blue exp %02h got %02h", want.blue_out, got.blue_out)};
			if (got.in_frame !== want.in_frame)
				diff = {diff, $sformatf(" in_frame exp %b got %b", want.in_frame, got.in_frame)};
			if (got.last_point !== want.last_point)
				diff = {diff, $sformatf(" last_point exp %b got %b", want.last_point,
					got.last_point)};
			if (diff != "")
				report($sformatf("pixel (%0d,%0d):%s", want.pixel_x, want.pixel_y, diff));
		endfunction
	endclass

endpackage

>>> tb/sv/bresenham_line_stepper_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bresenham_line_stepper_top_tb
// Drives line starts and step requests through the line stepper under
// random idling on both sides, across several frame sizes, and checks every
// pixel word against a scoreboard that rasterizes the same lines.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_top_tb;

	import bls_pkg::*;
	import bls_tb_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 200;
	localparam int HOLD_AFTER    = 300;

	logic                    clk    = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	dim_t                    cfg_data;
	logic                    req_valid;
	logic                    req_ready;
	req_t                    req;
	logic                    pix_valid;
	logic                    pix_ready;
	pix_t                    pix;

	line_scoreboard sb = new();
	int             stall_cycles = 0;
	bit             hold_done = 1'b0;

	bresenham_line_stepper_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Track accepted words on all three channels
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			sb.write_register(cfg_index, cfg_data);
		if (arst_n && req_valid && req_ready)
			sb.note_request(req);
		if (arst_n && pix_valid && pix_ready)
			sb.check_pixel(pix);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (pix_valid && pix_ready) ||
		    (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("bresenham_line_stepper_top regression: fail");
				$finish;
			end
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_gap();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		else if (sel < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic int clamp_coord(int v);
		if (v < -2048)
			return -2048;
		if (v > 2047)
			return 2047;
		return v;
	endfunction

	function automatic req_t rand_req(logic kind);
		req_t r;
		r.req_type = kind;
		r.start_x  = coord_t'($urandom_range(0, 4095));
		r.start_y  = coord_t'($urandom_range(0, 4095));
		r.end_x    = coord_t'($urandom_range(0, 4095));
		r.end_y    = coord_t'($urandom_range(0, 4095));
		r.red_in   = color_t'($urandom_range(0, 255));
		r.green_in = color_t'($urandom_range(0, 255));
		r.blue_in  = color_t'($urandom_range(0, 255));
		return r;
	endfunction

	function automatic req_t make_start(int x1, int y1, int x2, int y2,
	                                    int unsigned rgb);
		req_t r;
		r          = rand_req(REQ_START);
		r.start_x  = x1[COORD_BITS-1:0];
		r.start_y  = y1[COORD_BITS-1:0];
		r.end_x    = x2[COORD_BITS-1:0];
		r.end_y    = y2[COORD_BITS-1:0];
		r.red_in   = rgb[23:16];
		r.green_in = rgb[15:8];
		r.blue_in  = rgb[7:0];
		return r;
	endfunction

	// Pick a coordinate around the low edge, the high edge or inside
	function automatic int near_edge(int unsigned lim);
		int base;
		case ($urandom_range(0, 2))
			0:       base = 0;
			1:       base = int'(lim);
			default: base = int'($urandom_range(0, lim));
		endcase
		return clamp_coord(base + int'($urandom_range(0, 12)) - 6);
	endfunction

	// Offer one request word and hold it until taken
	task automatic send_req(input req_t r, input bit burst);
		int unsigned gap;
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		gap = burst ? 0 : idle_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Write all three frame registers back to back
	task automatic set_frame(input dim_t w, input dim_t h, input logic rdy);
		logic [CFG_IDX_BITS-1:0] idx[3];
		dim_t                    vals[3];
		idx[0]     = CFG_IMAGE_WIDTH;
		idx[1]     = CFG_IMAGE_HEIGHT;
		idx[2]     = CFG_TARGET_READY;
		vals[0]    = w;
		vals[1]    = h;
		vals[2]    = dim_t'($urandom_range(0, 2047));
		vals[2][0] = rdy;
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Wait until every owed pixel is out and the pipe has settled
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One start followed by a run of steps
	task automatic run_line(input int unsigned w, input int unsigned h);
		req_t        r;
		int          x1, y1, x2, y2, len;
		int unsigned mode, sel, n;
		bit          burst;
		mode  = $urandom_range(0, 19);
		burst = ($urandom_range(0, 3) == 0);
		if (mode < 14) begin
			x1 = near_edge(w);
			y1 = near_edge(h);
			x2 = clamp_coord(x1 + int'($urandom_range(0, 24)) - 12);
			y2 = clamp_coord(y1 + int'($urandom_range(0, 24)) - 12);
			r  = make_start(x1, y1, x2, y2, $urandom);
		end else if (mode < 17) begin
			// Axis-aligned, diagonal or single point
			x1 = near_edge(w);
			y1 = near_edge(h);
			x2 = x1;
			y2 = y1;
			sel = $urandom_range(0, 3);
			if (sel != 0)
				x2 = clamp_coord(x1 + int'($urandom_range(0, 16)) - 8);
			if (sel >= 2)
				y2 = clamp_coord(y1 + ((sel == 2) ? (x2 - x1) : (x1 - x2)));
			r = make_start(x1, y1, x2, y2, $urandom);
		end else begin
			// Anywhere in the coordinate range; cut short by the next start
			r  = rand_req(REQ_START);
			x1 = r.start_x;
			y1 = r.start_y;
			x2 = x1;
			y2 = y1;
		end
		dx_abs_len: begin
			int ax, ay;
			ax  = (x2 > x1) ? x2 - x1 : x1 - x2;
			ay  = (y2 > y1) ? y2 - y1 : y1 - y2;
			len = ((ax > ay) ? ax : ay) + 1;
		end
		sel = $urandom_range(0, 9);
		if (mode >= 17)
			n = $urandom_range(1, 12);
		else if (sel < 7)
			n = len;
		else if (sel < 9)
			n = $urandom_range(1, len);
		else
			n = len + $urandom_range(1, 2);
		send_req(r, burst);
		repeat (n) send_req(rand_req(REQ_STEP), burst);
	endtask

	// Program the frame, then run lines until the phase quota is met
	task automatic run_phase(input dim_t w, input dim_t h, input logic rdy,
	                         input int unsigned quota);
		int unsigned goal, sel;
		drain();
		set_frame(w, h, rdy);
		goal = sb.items_counted + quota;
		while (sb.items_counted < goal) begin
			sel = $urandom_range(0, 19);
			if (sel < 17)
				run_line(w, h);
			else if (sel < 19)
				send_req(rand_req(REQ_STEP), 1'b0);
			else
				send_req(rand_req(REQ_START), 1'b0);
		end
	endtask

	// Pixel side: stretches of ready with random gaps, one long hold-off
	initial begin
		int unsigned n;
		pix_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && sb.pixels_checked >= HOLD_AFTER) begin
				hold_done = 1'b1;
				pix_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			n = $urandom_range(1, 24);
			pix_ready <= 1'b1;
			repeat (n) @(posedge clk);
			n = idle_gap();
			if (n != 0) begin
				pix_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// Main sequence
	initial begin
		cfg_valid <= 1'b0;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data  <= '0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: step with no line, short line run past its end
		set_frame(11'd16, 11'd16, 1'b1);
		send_req(rand_req(REQ_STEP), 1'b0);
		send_req(make_start(0, 0, 3, 1, 24'hFF0080), 1'b0);
		repeat (5) send_req(rand_req(REQ_STEP), 1'b0);

		// Coordinate extremes, then a start that abandons the line
		send_req(make_start(-2048, -2048, 2047, 2047, 24'h000000), 1'b1);
		repeat (2) send_req(rand_req(REQ_STEP), 1'b1);
		send_req(make_start(2047, 2047, 2047, 2045, 24'hFFFFFF), 1'b0);
		repeat (4) send_req(rand_req(REQ_STEP), 1'b0);

		// Single-point line, then a line across the right clip edge
		send_req(make_start(5, 5, 5, 5, 24'h55AA33), 1'b0);
		send_req(rand_req(REQ_STEP), 1'b0);
		send_req(make_start(15, 3, 17, 3, 24'h123456), 1'b0);
		repeat (3) send_req(rand_req(REQ_STEP), 1'b0);

		// Shrink the frame while a line is still open
		send_req(make_start(2, 0, 2, -2, 24'hC0FFEE), 1'b0);
		send_req(rand_req(REQ_STEP), 1'b0);
		drain();
		set_frame(11'd0, 11'd16, 1'b1);
		repeat (2) send_req(rand_req(REQ_STEP), 1'b0);

		// Frame not ready: start is dropped, steps are ignored
		drain();
		set_frame(11'd16, 11'd16, 1'b0);
		send_req(make_start(1, 1, 4, 4, 24'h0F0F0F), 1'b0);
		send_req(rand_req(REQ_STEP), 1'b0);

		// Random phases over frame sizes, extremes included
		run_phase(11'd1024, 11'd1024, 1'b1, 210);
		run_phase(11'd2047, 11'd2047, 1'b1, 210);
		run_phase(11'd0, 11'd0, 1'b1, 160);
		run_phase(11'd16, 11'd9, 1'b1, 200);
		run_phase(11'd40, 11'd1030, 1'b0, 30);
		run_phase(dim_t'($urandom_range(1, 2047)), dim_t'($urandom_range(1, 2047)), 1'b1, 220);
		run_phase(dim_t'($urandom_range(1, 64)), dim_t'($urandom_range(1, 64)), 1'b1, 220);
		drain();

		$display("covered %0d line starts (%0d dropped), %0d pixels, %0d ignored steps",
			sb.starts, sb.drops, sb.pixels_checked, sb.idle_steps);
		$display("over %0d register writes with a %0d-cycle pixel hold-off; %0d mismatches",
			sb.cfg_writes, HOLD_CYCLES, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("bresenham_line_stepper_top regression: pass");
		end else begin
			$display("bresenham_line_stepper_top regression: fail");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/bls_pkg.sv
hw/rtl/bls_front.sv
hw/rtl/bls_queue.sv
hw/rtl/bls_back.sv
hw/rtl/bresenham_line_stepper_top.sv
hw/rtl/bls_checker.sv
tb/sv/bls_tb_pkg.sv
tb/sv/bresenham_line_stepper_top_tb.sv
